/* rtl/core/tsg_pkg.sv */
// Shared constants, codes and types of the three-channel square tone generator.
`default_nettype none

package tsg_pkg;

   // Channel datapath sizes.
   localparam int NUM_CHANNELS    = 3;
   localparam int CHAN_W          = 2;
   localparam int PERIOD_W        = 12;
   localparam int VOLUME_W        = 4;
   localparam int SUM_W           = 6;
   localparam int ADDR_W          = 16;
   localparam int DATA_W          = 8;
   localparam int SELECT_W        = 4;

   // Prescaler ahead of each period counter.
   localparam int PRESCALE_DIVIDE = 16;
   localparam int PRESCALE_W      = (PRESCALE_DIVIDE > 1) ? $clog2(PRESCALE_DIVIDE) : 1;

   // Bus address windows.
   localparam logic [ADDR_W-1:0] ADDR_SELECT_FIRST = 16'hC000;
   localparam logic [ADDR_W-1:0] ADDR_SELECT_LAST  = 16'hDFFF;
   localparam logic [ADDR_W-1:0] ADDR_DATA_FIRST   = 16'hE000;

   // Input action codes.
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Register indexes of the tone part.
   localparam logic [SELECT_W-1:0] REG_A_FINE   = 4'd0;
   localparam logic [SELECT_W-1:0] REG_A_COARSE = 4'd1;
   localparam logic [SELECT_W-1:0] REG_B_FINE   = 4'd2;
   localparam logic [SELECT_W-1:0] REG_B_COARSE = 4'd3;
   localparam logic [SELECT_W-1:0] REG_C_FINE   = 4'd4;
   localparam logic [SELECT_W-1:0] REG_C_COARSE = 4'd5;
   localparam logic [SELECT_W-1:0] REG_MIXER    = 4'd7;
   localparam logic [SELECT_W-1:0] REG_A_VOLUME = 4'd8;
   localparam logic [SELECT_W-1:0] REG_B_VOLUME = 4'd9;
   localparam logic [SELECT_W-1:0] REG_C_VOLUME = 4'd10;

   // Decoded operations passed from the front end to the back end.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_W-1:0] OP_PERIOD_LO = 3'd1;
   localparam logic [OP_W-1:0] OP_PERIOD_HI = 3'd2;
   localparam logic [OP_W-1:0] OP_MIXER     = 3'd3;
   localparam logic [OP_W-1:0] OP_VOLUME    = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAN_W-1:0] chan;
      logic [DATA_W-1:0] data;
   } cmd_type;

   // Queue sizes.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

endpackage

`default_nettype wire

/* rtl/core/tsg_front.sv */
// Front end: accepts words, tracks register select and lock, decodes operations.
`default_nettype none

module tsg_front
   import tsg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_action,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic              queue_full,
   output logic                   cmd_push,
   output cmd_type                cmd_word
);

   logic [SELECT_W-1:0] select_ff, select_in;
   logic                lock_ff, lock_in;
   logic                accept;
   logic                is_select_write;
   logic                is_data_write;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   assign is_select_write = (req_action == ACTION_WRITE)
                            && (req_address >= ADDR_SELECT_FIRST)
                            && (req_address <= ADDR_SELECT_LAST);
   assign is_data_write   = (req_action == ACTION_WRITE)
                            && (req_address >= ADDR_DATA_FIRST) && !lock_ff;

   // Select and lock follow every accepted write to the select window.
   always_comb begin
      select_in = select_ff;
      lock_in   = lock_ff;
      if (accept && is_select_write) begin
         select_in = req_write_data[SELECT_W-1:0];
         lock_in   = (req_write_data[DATA_W-1:SELECT_W] != '0);
      end
   end

   // Classify the word; ignored writes never reach the queue.
   always_comb begin
      cmd_push      = 1'b0;
      cmd_word.op   = OP_TICK;
      cmd_word.chan = '0;
      cmd_word.data = req_write_data;
      if (req_action == ACTION_TICK) begin
         cmd_push = accept;
      end else if (is_data_write) begin
         case (select_ff)
            REG_A_FINE, REG_B_FINE, REG_C_FINE: begin
               cmd_push      = accept;
               cmd_word.op   = OP_PERIOD_LO;
               cmd_word.chan = select_ff[CHAN_W:1];
            end
            REG_A_COARSE, REG_B_COARSE, REG_C_COARSE: begin
               cmd_push      = accept;
               cmd_word.op   = OP_PERIOD_HI;
               cmd_word.chan = select_ff[CHAN_W:1];
            end
            REG_MIXER: begin
               cmd_push    = accept;
               cmd_word.op = OP_MIXER;
            end
            REG_A_VOLUME, REG_B_VOLUME, REG_C_VOLUME: begin
               cmd_push      = accept;
               cmd_word.op   = OP_VOLUME;
               cmd_word.chan = select_ff[CHAN_W-1:0];
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff <= '0;
         lock_ff   <= 1'b0;
      end else begin
         select_ff <= select_in;
         lock_ff   <= lock_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tsg_cmd_queue.sv */
// Short queue of decoded operations between the front end and the back end.
`default_nettype none

module tsg_cmd_queue
   import tsg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_word,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_word
);

   cmd_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tsg_back.sv */
// Back end: channel registers, prescalers, period counters, mixer and result queue.
`default_nettype none

module tsg_back
   import tsg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire cmd_type          head_word,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [SUM_W-1:0]      rsp_mix_sum
);

   logic [PERIOD_W-1:0]   period_ff [NUM_CHANNELS];
   logic [PERIOD_W-1:0]   period_in [NUM_CHANNELS];
   logic [PERIOD_W-1:0]   count_ff [NUM_CHANNELS];
   logic [PERIOD_W-1:0]   count_in [NUM_CHANNELS];
   logic [PRESCALE_W-1:0] pre_ff [NUM_CHANNELS];
   logic [PRESCALE_W-1:0] pre_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] level_ff, level_in;
   logic [NUM_CHANNELS-1:0] off_ff, off_in;
   logic [VOLUME_W-1:0]   volume_ff [NUM_CHANNELS];
   logic [VOLUME_W-1:0]   volume_in [NUM_CHANNELS];
   logic [SUM_W-1:0]      sum;
   logic                  tick;

   logic [SUM_W-1:0]      rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  rsp_wr_ff, rsp_wr_in;
   logic [RSP_PTR_W-1:0]  rsp_rd_ff, rsp_rd_in;
   logic [RSP_CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_full;
   logic                  rsp_take;

   // A tick waits for room in the result queue; register writes never wait.
   assign rsp_full = (rsp_cnt_ff == RSP_CNT_W'(RSP_DEPTH));
   assign cmd_pop  = head_valid && ((head_word.op != OP_TICK) || !rsp_full);
   assign tick     = cmd_pop && (head_word.op == OP_TICK);

   // Register writes and per-channel counter advance.
   always_comb begin
      logic [PRESCALE_W:0] pre_next;
      logic [PERIOD_W:0]   cnt_next;
      period_in = period_ff;
      count_in  = count_ff;
      pre_in    = pre_ff;
      level_in  = level_ff;
      off_in    = off_ff;
      volume_in = volume_ff;
      pre_next  = '0;
      cnt_next  = '0;
      if (cmd_pop) begin
         case (head_word.op)
            OP_PERIOD_LO: begin
               period_in[head_word.chan][7:0] = head_word.data;
            end
            OP_PERIOD_HI: begin
               period_in[head_word.chan][PERIOD_W-1:8] = head_word.data[PERIOD_W-9:0];
            end
            OP_MIXER: begin
               off_in = head_word.data[NUM_CHANNELS-1:0];
            end
            OP_VOLUME: begin
               volume_in[head_word.chan] = head_word.data[VOLUME_W-1:0];
            end
            default: begin
            end
         endcase
      end
      if (tick) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pre_next = {1'b0, pre_ff[i]} + 1'b1;
            if (pre_next >= (PRESCALE_W + 1)'(PRESCALE_DIVIDE)) begin
               pre_in[i] = '0;
               cnt_next  = {1'b0, count_ff[i]} + 1'b1;
               if (cnt_next >= {1'b0, period_ff[i]}) begin
                  cnt_next    = '0;
                  level_in[i] = !level_ff[i];
               end
               count_in[i] = cnt_next[PERIOD_W-1:0];
            end else begin
               pre_in[i] = pre_next[PRESCALE_W-1:0];
            end
         end
      end
   end

   // Mix the channels that are enabled and high after this tick.
   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (!off_in[i] && level_in[i]) begin
            sum = sum + SUM_W'(volume_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            period_ff[i] <= '0;
            count_ff[i]  <= PERIOD_W'(1);
            pre_ff[i]    <= '0;
            volume_ff[i] <= '0;
         end
         level_ff <= '0;
         off_ff   <= '0;
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
         pre_ff    <= pre_in;
         level_ff  <= level_in;
         off_ff    <= off_in;
         volume_ff <= volume_in;
      end
   end

   // Result queue: one word per tick, read by the consumer in order.
   assign rsp_empty   = (rsp_cnt_ff == '0);
   assign rsp_take    = rsp_pop && !rsp_empty;
   assign rsp_mix_sum = rsp_mem_ff[rsp_rd_ff];

   always_comb begin
      rsp_wr_in  = rsp_wr_ff;
      rsp_rd_in  = rsp_rd_ff;
      rsp_cnt_in = rsp_cnt_ff;
      if (tick) begin
         rsp_wr_in = (rsp_wr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rsp_wr_ff + 1'b1;
      end
      if (rsp_take) begin
         rsp_rd_in = (rsp_rd_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rsp_rd_ff + 1'b1;
      end
      if (tick && !rsp_take) begin
         rsp_cnt_in = rsp_cnt_ff + 1'b1;
      end else if (rsp_take && !tick) begin
         rsp_cnt_in = rsp_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff  <= '0;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         rsp_wr_ff  <= rsp_wr_in;
         rsp_rd_ff  <= rsp_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_mem_ff[rsp_wr_ff] <= sum;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/three_channel_square_tone_generator_core.sv */
// Top level of the three-channel square tone generator.
//
//   Channel   Ports                                   Handshake
//   request   req_action, req_address, req_write_data push / full
//   response  rsp_mix_sum                             pop / empty
//
// One word can be taken every cycle while the operation queue is not full. A tick word
// passes through the operation queue and then the result queue, both registered, before
// its mix sum shows on the response ports. Writes yield no word.
// Reset is synchronous and clears all tone state.
// The request side stalls only when the four-entry operation queue is full,
// which happens when the four-entry result queue is full and ticks back up.
`default_nettype none

module three_channel_square_tone_generator_core
   import tsg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_action,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic [DATA_W-1:0] req_write_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [SUM_W-1:0]       rsp_mix_sum
);

   logic    queue_full;
   logic    cmd_push;
   cmd_type cmd_word;
   logic    head_valid;
   cmd_type head_word;
   logic    cmd_pop;

   tsg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .queue_full     (queue_full),
      .cmd_push       (cmd_push),
      .cmd_word       (cmd_word)
   );

   tsg_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_word  (cmd_word),
      .full       (queue_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   tsg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_word   (head_word),
      .cmd_pop     (cmd_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_mix_sum (rsp_mix_sum)
   );

endmodule

`default_nettype wire

/* rtl/core/tsg_checker.sv */
// Port-level checks of the tone generator and their attachment to the top level.
`default_nettype none

module tsg_checker
   import tsg_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire logic [SUM_W-1:0]  rsp_mix_sum
);

   // Reset leaves no result waiting.
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting right after reset");

   // Reset leaves the request side open.
   a_reset_open : assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full right after reset");

   // Three 4-bit volumes never sum above 45.
   a_sum_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_mix_sum <= 6'd45))
      else $error("mix sum out of range");

   // A waiting result stays put until taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_mix_sum)))
      else $error("waiting result changed before it was taken");

endmodule

bind three_channel_square_tone_generator_core tsg_checker u_tsg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_mix_sum    (rsp_mix_sum)
);

`default_nettype wire

/* bench/tone_mix_check_pkg.sv */
// Scoreboard class that predicts and checks the mix sums of the tone generator.
package tone_mix_check_pkg;
   import tsg_pkg::*;

   class tone_mix_scoreboard;
      logic [SELECT_W-1:0] reg_select;
      logic                locked;
      logic [PERIOD_W-1:0] period [NUM_CHANNELS];
      logic [PERIOD_W-1:0] count [NUM_CHANNELS];
      int unsigned         prescale [NUM_CHANNELS];
      logic                level [NUM_CHANNELS];
      logic [VOLUME_W-1:0] volume [NUM_CHANNELS];
      logic                muted [NUM_CHANNELS];
      logic [SUM_W-1:0]    mix_sums_due [$];
      int unsigned         checked;
      int unsigned         errors;

      // State right after reset: every period counter starts at one.
      function new();
         reg_select = '0;
         locked     = 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            period[i]   = '0;
            count[i]    = PERIOD_W'(1);
            prescale[i] = 0;
            level[i]    = 1'b0;
            volume[i]   = '0;
            muted[i]    = 1'b0;
         end
         checked = 0;
         errors  = 0;
      endfunction

      // A select-window write latches the register and the lock; a data write
      // updates the selected register unless the lock is set.
      function void bus_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         int ch;
         if (addr >= ADDR_SELECT_FIRST && addr <= ADDR_SELECT_LAST) begin
            locked     = (data[7:4] != 4'h0);
            reg_select = data[SELECT_W-1:0];
            return;
         end
         if (addr < ADDR_DATA_FIRST || locked) return;
         ch = reg_select >> 1;
         case (reg_select)
            REG_A_FINE, REG_B_FINE, REG_C_FINE: begin
               period[ch][7:0] = data;
            end
            REG_A_COARSE, REG_B_COARSE, REG_C_COARSE: begin
               period[ch][PERIOD_W-1:8] = data[3:0];
            end
            REG_MIXER: begin
               for (int i = 0; i < NUM_CHANNELS; i++) muted[i] = data[i];
            end
            REG_A_VOLUME, REG_B_VOLUME, REG_C_VOLUME: begin
               volume[reg_select - REG_A_VOLUME] = data[VOLUME_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // One tick: step prescalers and period counters, then sum the sounding volumes.
      function void tick();
         logic [PERIOD_W:0] next_count;
         logic [SUM_W-1:0]  sum;
         sum = '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            prescale[i] = prescale[i] + 1;
            if (prescale[i] >= PRESCALE_DIVIDE) begin
               prescale[i] = 0;
               next_count  = {1'b0, count[i]} + 1'b1;
               if (next_count >= {1'b0, period[i]}) begin
                  next_count = '0;
                  level[i]   = ~level[i];
               end
               count[i] = next_count[PERIOD_W-1:0];
            end
         end
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!muted[i] && level[i]) sum = sum + SUM_W'(volume[i]);
         end
         mix_sums_due = {mix_sums_due, sum};
      endfunction

      // Called for every word the block accepts on its request side.
      function void note_word(logic action, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         if (action == ACTION_WRITE) bus_write(addr, data);
         else tick();
      endfunction

      // Called for every word taken from the response side.
      function void check_word(logic [SUM_W-1:0] actual);
         logic [SUM_W-1:0] due;
         if (mix_sums_due.size() == 0) begin
            errors++;
            $display("%0t: mix_sum expected none, actual %0d", $time, actual);
            return;
         end
         due = mix_sums_due.pop_front();
         checked++;
         if (actual !== due) begin
            errors++;
            $display("%0t: mix_sum expected %0d, actual %0d", $time, due, actual);
         end
      endfunction

      function int pending();
         return mix_sums_due.size();
      endfunction
   endclass

endpackage

/* bench/tb.sv */
// Top-level testbench that drives the tone generator and checks every mix sum.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsg_pkg::*;
   import tone_mix_check_pkg::*;

   localparam int ITEM_TARGET  = 1900;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PERCENT = 11;

   // Selects outside the tone part: noise period and the envelope range.
   localparam logic [SELECT_W-1:0] SEL_NOISE_PERIOD = 4'd6;
   localparam logic [SELECT_W-1:0] SEL_ENV_FIRST    = 4'd11;
   localparam logic [SELECT_W-1:0] SEL_ENV_LAST     = 4'd15;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_push       = 1'b0;
   logic              req_full;
   logic              req_action     = ACTION_TICK;
   logic [ADDR_W-1:0] req_address    = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_empty;
   logic              rsp_pop        = 1'b0;
   logic [SUM_W-1:0]  rsp_mix_sum;

   tone_mix_scoreboard sb = new();

   int unsigned words_sent   = 0;
   int unsigned ticks_taken  = 0;
   int unsigned stall_cycles = 0;
   int unsigned holds_asked  = 0;
   int unsigned holds_done   = 0;
   int unsigned hold_left    = 0;
   bit          steady       = 1'b0;

   three_channel_square_tone_generator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_mix_sum    (rsp_mix_sum)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watch both handshakes at each edge; any accepted word resets the stall count.
   always @(posedge clock) begin
      if (!reset) begin
         stall_cycles = stall_cycles + 1;
         if (req_push && !req_full) begin
            sb.note_word(req_action, req_address, req_write_data);
            if (req_action == ACTION_TICK) ticks_taken++;
            stall_cycles = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_word(rsp_mix_sum);
            stall_cycles = 0;
         end
      end
   end

   // Response side: random pops, a steady stretch, and one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop   <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_done < holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // The run fails if nothing moves on either side for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Offer one word and hold it until the block takes it; then maybe idle before the next word.
   task automatic send_word(input logic act, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      req_action     <= act;
      req_address    <= addr;
      req_write_data <= data;
      req_push       <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Ticks carry random address and data, which the block must ignore.
   task automatic tick_run(input int n);
      repeat (n) send_word(ACTION_TICK, ADDR_W'($urandom_range(0, 65535)),
                           DATA_W'($urandom_range(0, 255)));
   endtask

   // Unlocked select followed by a data write, at random spots in both windows.
   task automatic write_reg(input logic [SELECT_W-1:0] sel, input logic [DATA_W-1:0] data);
      send_word(ACTION_WRITE, ADDR_W'($urandom_range(ADDR_SELECT_FIRST, ADDR_SELECT_LAST)),
                {4'h0, sel});
      send_word(ACTION_WRITE, ADDR_W'($urandom_range(ADDR_DATA_FIRST, 16'hFFFF)), data);
   endtask

   function automatic logic [SELECT_W-1:0] random_select();
      int k;
      k = $urandom_range(0, 11);
      case (k)
         0:       return REG_A_FINE;
         1:       return REG_A_COARSE;
         2:       return REG_B_FINE;
         3:       return REG_B_COARSE;
         4:       return REG_C_FINE;
         5:       return REG_C_COARSE;
         6:       return REG_MIXER;
         7:       return REG_A_VOLUME;
         8:       return REG_B_VOLUME;
         9:       return REG_C_VOLUME;
         10:      return SEL_NOISE_PERIOD;
         default: return SELECT_W'($urandom_range(SEL_ENV_FIRST, SEL_ENV_LAST));
      endcase
   endfunction

   // Periods are mostly kept short so that the square outputs toggle within the run.
   function automatic logic [DATA_W-1:0] random_reg_data(input logic [SELECT_W-1:0] sel);
      logic [DATA_W-1:0] d;
      d = DATA_W'($urandom_range(0, 255));
      case (sel)
         REG_A_FINE, REG_B_FINE, REG_C_FINE: begin
            if ($urandom_range(0, 3) != 0) d = DATA_W'($urandom_range(0, 6));
         end
         REG_A_COARSE, REG_B_COARSE, REG_C_COARSE: begin
            if ($urandom_range(0, 3) != 0) d[3:0] = 4'h0;
         end
         default: begin
         end
      endcase
      return d;
   endfunction

   initial begin
      int pick;
      logic [SELECT_W-1:0] sel;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a tick straight out of reset and writes below the select window.
      send_word(ACTION_TICK, 16'hFFFF, 8'hFF);
      send_word(ACTION_WRITE, 16'h0000, 8'hFF);
      send_word(ACTION_WRITE, ADDR_SELECT_FIRST - 1'b1, {4'h0, REG_A_VOLUME});

      // Volumes at the window edges; only the low nibble counts.
      send_word(ACTION_WRITE, ADDR_SELECT_FIRST, {4'h0, REG_A_VOLUME});
      send_word(ACTION_WRITE, ADDR_DATA_FIRST, 8'hFF);
      send_word(ACTION_WRITE, ADDR_SELECT_LAST, {4'h0, REG_B_VOLUME});
      send_word(ACTION_WRITE, 16'hFFFF, 8'h1A);
      write_reg(REG_C_VOLUME, 8'hE7);

      // Largest period on channel A through both bytes.
      write_reg(REG_A_FINE, 8'hFF);
      write_reg(REG_A_COARSE, 8'hFF);

      // A select with the upper nibble set locks out the next data write.
      send_word(ACTION_WRITE, ADDR_SELECT_FIRST, {4'hF, REG_A_VOLUME});
      send_word(ACTION_WRITE, ADDR_DATA_FIRST, 8'h00);

      // Mixer with only the upper bits set, then the unsounded selects.
      write_reg(REG_MIXER, 8'hF8);
      write_reg(SEL_NOISE_PERIOD, 8'hFF);
      write_reg(SEL_ENV_LAST, 8'hFF);

      // Zero period on channel B toggles on every prescaler wrap.
      write_reg(REG_B_FINE, 8'h00);
      write_reg(REG_B_COARSE, 8'h00);
      tick_run(2);

      // Random part: mostly well-formed register writes and tick runs.
      while (words_sent < ITEM_TARGET) begin
         steady = (words_sent >= 500 && words_sent < 800);
         if (words_sent >= 1200 && holds_asked == 0) begin
            holds_asked = 1;
            tick_run(40);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            tick_run($urandom_range(1, 24));
         end else if (pick < 80) begin
            sel = random_select();
            write_reg(sel, random_reg_data(sel));
         end else if (pick < 88) begin
            sel = random_select();
            send_word(ACTION_WRITE,
                      ADDR_W'($urandom_range(ADDR_SELECT_FIRST, ADDR_SELECT_LAST)),
                      {4'($urandom_range(1, 15)), sel});
            send_word(ACTION_WRITE, ADDR_W'($urandom_range(ADDR_DATA_FIRST, 16'hFFFF)),
                      DATA_W'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            send_word(ACTION_WRITE, ADDR_W'($urandom_range(ADDR_DATA_FIRST, 16'hFFFF)),
                      DATA_W'($urandom_range(0, 255)));
         end else begin
            send_word(1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)));
         end
      end
      steady = 1'b0;
      req_push <= 1'b0;

      // Drain the response side, then give stray words a chance to show up.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words, %0d of them ticks; checked %0d mix sums.",
               words_sent, ticks_taken, sb.checked);
      $display("Covered lock, ignored selects, zero periods and a %0d-cycle response stall.",
               HOLD_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/tsg_pkg.sv
rtl/core/tsg_front.sv
rtl/core/tsg_cmd_queue.sv
rtl/core/tsg_back.sv
rtl/core/three_channel_square_tone_generator_core.sv
rtl/core/tsg_checker.sv
bench/tone_mix_check_pkg.sv
bench/tb.sv
